// File: rtl/rfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the range frame check and trimmed mean unit.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int WINDOW_DEN = WINDOW_LEN - 2;
    localparam int DIST_W     = 16;
    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int SUM_W      = DIST_W + $clog2(WINDOW_LEN);
    localparam int WIDE_W     = SUM_W + 4;
    localparam int FILT_W     = 20;
    localparam int CFG_IDX_W  = 2;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [WIDE_W-1:0] t_wide;
    typedef logic [FILT_W-1:0] t_filt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam logic [7:0] FRAME_HEADER = 8'hFF;
    localparam t_slot      LAST_SLOT    = t_slot'(WINDOW_LEN - 1);

    localparam t_dist RST_MIN_DIST  = t_dist'(200);
    localparam t_dist RST_MAX_DIST  = t_dist'(6000);
    localparam t_dist RST_SPIKE_THR = t_dist'(200);

    localparam t_cfg_idx REG_MIN_DIST  = 2'd0;
    localparam t_cfg_idx REG_MAX_DIST  = 2'd1;
    localparam t_cfg_idx REG_SPIKE_THR = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef struct packed {
        logic       timed_out;
        logic [7:0] header_byte;
        logic [7:0] dist_high;
        logic [7:0] dist_low;
        logic [7:0] check_byte;
    } t_frame;

    typedef struct packed {
        t_status status;
        t_dist   raw;
    } t_stage;

    typedef struct packed {
        logic  en;
        t_dist value;
    } t_hist_wr;

    typedef struct packed {
        t_status status;
        t_dist   raw;
        t_sum    trim_sum;
    } t_stats;

    typedef struct packed {
        t_status status;
        t_dist   raw_distance_mm;
        t_filt   filtered_distance;
        logic    spike_rejected;
    } t_result;

endpackage

// File: rtl/rfc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_in_if
// Frame channel: valid/ready handshake with one ranging frame per item.
// ----------------------------------------------------------------------------
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic       timed_out;
    logic [7:0] header_byte;
    logic [7:0] dist_high;
    logic [7:0] dist_low;
    logic [7:0] check_byte;

    modport source (
        output valid, timed_out, header_byte, dist_high, dist_low, check_byte,
        input  ready
    );
    modport sink (
        input  valid, timed_out, header_byte, dist_high, dist_low, check_byte,
        output ready
    );
endinterface

// File: rtl/rfc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_out_if
// Result channel: valid/ready handshake with one filtered distance per item.
// ----------------------------------------------------------------------------
interface rfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] raw_distance_mm;
    logic [19:0] filtered_distance;
    logic        spike_rejected;

    modport source (
        output valid, status, raw_distance_mm, filtered_distance, spike_rejected,
        input  ready
    );
    modport sink (
        input  valid, status, raw_distance_mm, filtered_distance, spike_rejected,
        output ready
    );
endinterface

// File: rtl/rfc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_check
// Input register and frame check: header, checksum and range limits.
// ----------------------------------------------------------------------------
module rfc_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rfc_pkg::t_frame   i_frame,
    input  rfc_pkg::t_dist    i_min_dist,
    input  rfc_pkg::t_dist    i_max_dist,
    output logic              o_valid,
    input  logic              i_ready,
    output rfc_pkg::t_stage   o_stage,
    output rfc_pkg::t_hist_wr o_wr
);

    logic            r_v1;
    rfc_pkg::t_frame r_f1;
    logic            r_v2;
    rfc_pkg::t_stage r_s2;
    rfc_pkg::t_stage n_s2;
    logic            adv1;
    logic [7:0]      n_chk;
    rfc_pkg::t_dist  n_raw;

    assign adv1    = !r_v2 || i_ready;
    assign o_ready = !r_v1 || adv1;

    always_comb begin
        n_raw = {r_f1.dist_high, r_f1.dist_low};
        n_chk = rfc_pkg::FRAME_HEADER + r_f1.dist_high + r_f1.dist_low;
        n_s2.raw = '0;
        priority if (r_f1.timed_out) begin
            n_s2.status = rfc_pkg::ST_TIMEOUT;
        end else if (r_f1.header_byte != rfc_pkg::FRAME_HEADER ||
                     n_chk != r_f1.check_byte ||
                     n_raw < i_min_dist || n_raw > i_max_dist) begin
            n_s2.status = rfc_pkg::ST_BAD;
        end else begin
            n_s2.status = rfc_pkg::ST_OK;
            n_s2.raw    = n_raw;
        end
    end

    // history is written as the item moves on, so the next stage sees it
    assign o_wr.en    = r_v1 && adv1 && (n_s2.status == rfc_pkg::ST_OK);
    assign o_wr.value = n_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (adv1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_f1 <= i_frame;
        end
        if (adv1) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_stage = r_s2;

endmodule

// File: rtl/rfc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_window
// Distance history ring with sum, minimum and maximum for the trimmed sum.
// ----------------------------------------------------------------------------
module rfc_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfc_pkg::t_hist_wr i_wr,
    input  logic              i_valid,
    output logic              o_ready,
    input  rfc_pkg::t_stage   i_stage,
    output logic              o_valid,
    input  logic              i_ready,
    output rfc_pkg::t_stats   o_stats
);

    rfc_pkg::t_dist  r_win [rfc_pkg::WINDOW_LEN];
    rfc_pkg::t_slot  r_slot;
    logic            r_v3;
    rfc_pkg::t_stats r_s3;
    rfc_pkg::t_sum   n_sum;
    rfc_pkg::t_dist  n_min;
    rfc_pkg::t_dist  n_max;
    rfc_pkg::t_sum   n_trim;

    assign o_ready = !r_v3 || i_ready;

    always_comb begin
        n_sum = '0;
        n_min = '1;
        n_max = '0;
        for (int i = 0; i < rfc_pkg::WINDOW_LEN; i++) begin
            n_sum = n_sum + rfc_pkg::t_sum'(r_win[i]);
            if (r_win[i] < n_min) begin
                n_min = r_win[i];
            end
            if (r_win[i] > n_max) begin
                n_max = r_win[i];
            end
        end
        n_trim = n_sum - rfc_pkg::t_sum'(n_min) - rfc_pkg::t_sum'(n_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rfc_pkg::WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_slot <= '0;
            r_v3   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_win[r_slot] <= i_wr.value;
                r_slot <= (r_slot == rfc_pkg::LAST_SLOT) ? '0 : r_slot + 1'b1;
            end
            if (o_ready) begin
                r_v3 <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s3.status   <= i_stage.status;
            r_s3.raw      <= i_stage.raw;
            r_s3.trim_sum <= n_trim;
        end
    end

    assign o_valid = r_v3;
    assign o_stats = r_s3;

endmodule

// File: rtl/rfc_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_filter
// Trimmed mean, spike decision and blend into the result register.
// ----------------------------------------------------------------------------
module rfc_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfc_pkg::t_dist   i_spike_thr,
    input  logic             i_valid,
    output logic             o_ready,
    input  rfc_pkg::t_stats  i_stats,
    output logic             o_valid,
    input  logic             i_ready,
    output rfc_pkg::t_result o_result
);

    logic             r_vo;
    rfc_pkg::t_result r_res;
    rfc_pkg::t_result n_res;
    rfc_pkg::t_wide   n_a;
    rfc_pkg::t_wide   n_s;
    rfc_pkg::t_wide   n_diff;
    rfc_pkg::t_wide   n_lim;
    rfc_pkg::t_wide   n_mean;
    rfc_pkg::t_wide   n_blend;
    logic             n_spike;

    assign o_ready = !r_vo || i_ready;

    always_comb begin
        n_s     = rfc_pkg::t_wide'(i_stats.trim_sum);
        n_a     = rfc_pkg::t_wide'(i_stats.raw) * rfc_pkg::t_wide'(rfc_pkg::WINDOW_DEN);
        n_lim   = rfc_pkg::t_wide'(i_spike_thr) * rfc_pkg::t_wide'(rfc_pkg::WINDOW_DEN);
        n_diff  = (n_a > n_s) ? (n_a - n_s) : (n_s - n_a);
        n_spike = n_diff > n_lim;
        n_mean  = rfc_pkg::t_wide'((n_s << 4) / rfc_pkg::WINDOW_DEN);
        n_blend = rfc_pkg::t_wide'(((n_a + n_s) << 3) / rfc_pkg::WINDOW_DEN);

        n_res.status = i_stats.status;
        if (i_stats.status == rfc_pkg::ST_OK) begin
            n_res.raw_distance_mm   = i_stats.raw;
            n_res.spike_rejected    = n_spike;
            n_res.filtered_distance = n_spike ? n_mean[rfc_pkg::FILT_W-1:0]
                                              : n_blend[rfc_pkg::FILT_W-1:0];
        end else begin
            n_res.raw_distance_mm   = '0;
            n_res.spike_rejected    = 1'b0;
            n_res.filtered_distance = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (o_ready) begin
            r_vo <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_vo;
    assign o_result = r_res;

endmodule

// File: rtl/range_frame_check_trimmed_mean_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_frame_check_trimmed_mean_unit
// Ranging frame checker with a trimmed mean moving window filter.
// ----------------------------------------------------------------------------
// i_frame carries one item per handshake: a timeout mark or a frame of header,
// distance bytes and checksum. o_result returns one item per frame with the
// status, the accepted raw distance and the filtered distance in 1/16 mm.
// limits and spike threshold are written through i_cfg_we/i_cfg_idx/i_cfg_wdata
// only while no item is in flight, a rule on the user that the block itself does
// not enforce; unknown indexes are ignored
// while the receiver takes results, one item per cycle is sustained through
// four register stages (input, check, window statistics, result)
// the ten-entry history is written when a good frame leaves the input register,
// so sum, minimum and maximum see that frame and the good frames ahead of it
// reset clears the history, the write slot, all stage valids and restores
// the register defaults
// a stalled receiver holds the result; stages behind it keep filling until
// all are full, and only then is i_frame.ready dropped
// ----------------------------------------------------------------------------
module range_frame_check_trimmed_mean_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rfc_in_if.sink                    i_frame,
    rfc_out_if.source                 o_result,
    input  logic                      i_cfg_we,
    input  rfc_pkg::t_cfg_idx         i_cfg_idx,
    input  rfc_pkg::t_dist            i_cfg_wdata
);

    rfc_pkg::t_dist    r_min_dist;
    rfc_pkg::t_dist    r_max_dist;
    rfc_pkg::t_dist    r_spike_thr;
    rfc_pkg::t_frame   frame;
    rfc_pkg::t_stage   stage;
    rfc_pkg::t_hist_wr hist_wr;
    rfc_pkg::t_stats   stats;
    rfc_pkg::t_result  result;
    logic              chk_valid;
    logic              win_ready;
    logic              win_valid;
    logic              flt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= rfc_pkg::RST_MIN_DIST;
            r_max_dist  <= rfc_pkg::RST_MAX_DIST;
            r_spike_thr <= rfc_pkg::RST_SPIKE_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfc_pkg::REG_MIN_DIST:  r_min_dist  <= i_cfg_wdata;
                rfc_pkg::REG_MAX_DIST:  r_max_dist  <= i_cfg_wdata;
                rfc_pkg::REG_SPIKE_THR: r_spike_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign frame.timed_out   = i_frame.timed_out;
    assign frame.header_byte = i_frame.header_byte;
    assign frame.dist_high   = i_frame.dist_high;
    assign frame.dist_low    = i_frame.dist_low;
    assign frame.check_byte  = i_frame.check_byte;

    rfc_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_frame.valid),
        .o_ready    (i_frame.ready),
        .i_frame    (frame),
        .i_min_dist (r_min_dist),
        .i_max_dist (r_max_dist),
        .o_valid    (chk_valid),
        .i_ready    (win_ready),
        .o_stage    (stage),
        .o_wr       (hist_wr)
    );

    rfc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (hist_wr),
        .i_valid (chk_valid),
        .o_ready (win_ready),
        .i_stage (stage),
        .o_valid (win_valid),
        .i_ready (flt_ready),
        .o_stats (stats)
    );

    rfc_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spike_thr (r_spike_thr),
        .i_valid     (win_valid),
        .o_ready     (flt_ready),
        .i_stats     (stats),
        .o_valid     (o_result.valid),
        .i_ready     (o_result.ready),
        .o_result    (result)
    );

    assign o_result.status            = result.status;
    assign o_result.raw_distance_mm   = result.raw_distance_mm;
    assign o_result.filtered_distance = result.filtered_distance;
    assign o_result.spike_rejected    = result.spike_rejected;

    a_err_zeroed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status != rfc_pkg::ST_OK |->
            o_result.raw_distance_mm == '0 && o_result.filtered_distance == '0 &&
            !o_result.spike_rejected)
        else $error("error item carries a nonzero payload");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_frame.ready |-> o_result.valid && !o_result.ready)
        else $error("input stalled while the result side can move");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

endmodule

// File: tb/rfc_result_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_result_monitor
// Watches the frame and result channels of the range frame check unit. Every
// accepted frame is run through a local model of the frame checks and of the
// trimmed mean window, and the expected result is queued. Every accepted
// result is compared field by field with the oldest queued one. The register
// port is tracked so the local limits follow every write.
// ----------------------------------------------------------------------------
module rfc_result_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rfc_in_if                   i_frame,
    rfc_out_if                  i_result,
    input  logic                i_cfg_we,
    input  rfc_pkg::t_cfg_idx   i_cfg_idx,
    input  rfc_pkg::t_dist      i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_spikes
);
    import rfc_pkg::*;

    t_dist   lim_min;
    t_dist   lim_max;
    t_dist   spike_thr;
    t_dist   history [WINDOW_LEN];
    t_slot   wslot;
    t_result awaited_readings [$];
    t_result want;
    t_frame  seen;

    function automatic t_result predict_reading(input t_frame f);
        t_result r;
        t_dist raw;
        logic [7:0] csum;
        longint unsigned total, lo_v, hi_v, scaled, diff, den;
        r = '0;
        den = WINDOW_DEN;
        raw = {f.dist_high, f.dist_low};
        csum = FRAME_HEADER + f.dist_high + f.dist_low;
        if (f.timed_out) begin
            r.status = ST_TIMEOUT;
            return r;
        end
        if (f.header_byte != FRAME_HEADER || csum != f.check_byte ||
            raw < lim_min || raw > lim_max) begin
            r.status = ST_BAD;
            return r;
        end
        history[wslot] = raw;
        wslot = (wslot == LAST_SLOT) ? '0 : wslot + 1'b1;
        total = 0;
        lo_v = 64'hFFFF;
        hi_v = 0;
        foreach (history[i]) begin
            total += history[i];
            if (history[i] < lo_v) lo_v = history[i];
            if (history[i] > hi_v) hi_v = history[i];
        end
        total -= lo_v + hi_v;
        scaled = raw * den;
        diff = (scaled > total) ? scaled - total : total - scaled;
        r.status = ST_OK;
        r.raw_distance_mm = raw;
        r.spike_rejected = (diff > spike_thr * den);
        r.filtered_distance = r.spike_rejected ? t_filt'(total * 16 / den)
                                               : t_filt'((scaled + total) * 8 / den);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_min = RST_MIN_DIST;
            lim_max = RST_MAX_DIST;
            spike_thr = RST_SPIKE_THR;
            foreach (history[i]) history[i] = '0;
            wslot = '0;
            awaited_readings.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_spikes = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_DIST:  lim_min = i_cfg_wdata;
                    REG_MAX_DIST:  lim_max = i_cfg_wdata;
                    REG_SPIKE_THR: spike_thr = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (awaited_readings.size() == 0) begin
                    $error("result item with nothing awaited");
                    o_fail_count++;
                end else begin
                    want = awaited_readings.pop_front();
                    o_checked++;
                    if (want.spike_rejected) o_spikes++;
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_result.status);
                        o_fail_count++;
                    end
                    if (i_result.raw_distance_mm !== want.raw_distance_mm) begin
                        $error("raw_distance_mm: expected %0d, actual %0d",
                               want.raw_distance_mm, i_result.raw_distance_mm);
                        o_fail_count++;
                    end
                    if (i_result.filtered_distance !== want.filtered_distance) begin
                        $error("filtered_distance: expected %0d, actual %0d",
                               want.filtered_distance, i_result.filtered_distance);
                        o_fail_count++;
                    end
                    if (i_result.spike_rejected !== want.spike_rejected) begin
                        $error("spike_rejected: expected %0d, actual %0d",
                               want.spike_rejected, i_result.spike_rejected);
                        o_fail_count++;
                    end
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                seen.timed_out = i_frame.timed_out;
                seen.header_byte = i_frame.header_byte;
                seen.dist_high = i_frame.dist_high;
                seen.dist_low = i_frame.dist_low;
                seen.check_byte = i_frame.check_byte;
                awaited_readings.push_back(predict_reading(seen));
            end
        end
        o_pending = awaited_readings.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the range frame check and trimmed mean unit. A directed
// part covers timeouts, bad headers and checksums, range edges, an empty
// and a flat history and crossed limits; random phases then run drifting,
// jumping and spiking distances mixed with broken frames under several
// register settings, with random idling, a long receiver stall and a calm
// stretch. Checking is done by rfc_result_monitor.
// ----------------------------------------------------------------------------
module testbench;
    import rfc_pkg::*;

    localparam int       CYCLE_LIMIT   = 200000;
    localparam int       PHASE_ITEMS   = 238;
    localparam int       PHASE_COUNT   = 6;
    localparam int       STALL_CYCLES  = 80;
    localparam t_cfg_idx REG_UNUSED    = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_dist    i_cfg_wdata;

    int    fail_count;
    int    pending;
    int    checked;
    int    spikes;
    int    cycle_count;
    int    sent;
    int    setting_count;
    int    level;
    bit    calm;
    bit    stall_req;
    t_dist cfg_min;
    t_dist cfg_max;
    t_dist cfg_thr;

    rfc_in_if  frame_bus ();
    rfc_out_if result_bus ();

    range_frame_check_trimmed_mean_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame_bus),
        .o_result    (result_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rfc_result_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame_bus),
        .i_result     (result_bus),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_spikes     (spikes)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("range_frame_check_trimmed_mean_unit regression: fail");
        $finish;
    end

    // result side: random back-pressure, long hold-off on request
    initial begin
        bit stall_seen;
        int stall_left;
        stall_seen = 1'b0;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else if (calm) begin
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    function automatic t_frame good_frame(input t_dist d);
        t_frame f;
        f.timed_out = 1'b0;
        f.header_byte = FRAME_HEADER;
        f.dist_high = d[15:8];
        f.dist_low = d[7:0];
        f.check_byte = FRAME_HEADER + d[15:8] + d[7:0];
        return f;
    endfunction

    function automatic t_frame next_frame();
        t_frame f;
        int pick, sub, d, lo, hi, k;
        lo = cfg_min;
        hi = cfg_max;
        k = cfg_thr / 8 + 4;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (lo > hi) begin
            d = $urandom_range(0, 65535);
        end else if (sub < 60) begin
            level = level + int'($urandom_range(0, 2 * k)) - k;
            if (level < lo) level = lo;
            if (level > hi) level = hi;
            d = level;
        end else if (sub < 75) begin
            d = level;
        end else if (sub < 90) begin
            d = $urandom_range(hi, lo);
        end else begin
            level = $urandom_range(hi, lo);
            d = level;
        end
        f = good_frame(t_dist'(d));
        if (pick < 8) begin
            f = t_frame'({$urandom(), $urandom()});
            f.timed_out = 1'b1;
        end else if (pick < 12) begin
            f.header_byte = 8'($urandom_range(0, 254));
        end else if (pick < 16) begin
            f.check_byte = f.check_byte ^ (8'd1 << $urandom_range(0, 7));
        end else if (pick < 20) begin
            if (lo > 0 && ($urandom_range(0, 1) == 1 || hi == 65535))
                d = $urandom_range(0, lo - 1);
            else if (hi < 65535)
                d = $urandom_range(hi + 1, 65535);
            else
                d = $urandom_range(0, 65535);
            f = good_frame(t_dist'(d));
        end
        return f;
    endfunction

    task automatic push_frame(input t_frame f);
        if (!calm) begin
            while ($urandom_range(0, 99) < 25) begin
                frame_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        frame_bus.valid <= 1'b1;
        frame_bus.timed_out <= f.timed_out;
        frame_bus.header_byte <= f.header_byte;
        frame_bus.dist_high <= f.dist_high;
        frame_bus.dist_low <= f.dist_low;
        frame_bus.check_byte <= f.check_byte;
        @(posedge i_clk);
        while (!frame_bus.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic settle();
        frame_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apply_config(input t_dist mn, input t_dist mx, input t_dist thr,
                                input bit poke_unused);
        t_cfg_idx idx [4];
        t_dist    val [4];
        int       n;
        idx = '{REG_MIN_DIST, REG_MAX_DIST, REG_SPIKE_THR, REG_UNUSED};
        val = '{mn, mx, thr, t_dist'($urandom())};
        n = poke_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_wdata <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_min = mn;
        cfg_max = mx;
        cfg_thr = thr;
        level = (int'(mn) + int'(mx)) / 2;
        setting_count++;
    endtask

    initial begin
        t_frame f;
        int     mn, mx;
        sent = 0;
        setting_count = 0;
        calm = 1'b0;
        stall_req = 1'b0;
        cfg_min = RST_MIN_DIST;
        cfg_max = RST_MAX_DIST;
        cfg_thr = RST_SPIKE_THR;
        level = 1000;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_MIN_DIST;
        i_cfg_wdata <= '0;
        frame_bus.valid <= 1'b0;
        frame_bus.timed_out <= 1'b0;
        frame_bus.header_byte <= '0;
        frame_bus.dist_high <= '0;
        frame_bus.dist_low <= '0;
        frame_bus.check_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: timeouts, broken frames, range edges, zero history
        f = good_frame(16'd1000);
        f.timed_out = 1'b1;
        push_frame(f);
        f = t_frame'({$urandom(), $urandom()});
        f.timed_out = 1'b1;
        push_frame(f);
        f = good_frame(16'd1000);
        f.header_byte = 8'h7F;
        push_frame(f);
        f = good_frame(16'd1000);
        f.check_byte = f.check_byte ^ 8'h01;
        push_frame(f);
        push_frame(good_frame(16'd199));
        push_frame(good_frame(16'd6001));
        push_frame(good_frame(16'd200));
        push_frame(good_frame(16'd6000));
        // flat history so both extremes are equal
        repeat (11) push_frame(good_frame(16'd1000));

        // widest limits, zero threshold
        settle();
        apply_config(16'd0, 16'hFFFF, 16'd0, 1'b1);
        push_frame(good_frame(16'd0));
        push_frame(good_frame(16'hFFFF));
        push_frame(good_frame(16'h00FF));
        push_frame(good_frame(16'hFF00));

        // crossed limits
        settle();
        apply_config(16'd5000, 16'd100, 16'hFFFF, 1'b0);
        push_frame(good_frame(16'd1000));
        push_frame(good_frame(16'd5000));

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            calm = (ph == 1);
            case (ph)
                0: apply_config(RST_MIN_DIST, RST_MAX_DIST, RST_SPIKE_THR, 1'b0);
                1: apply_config(16'd0, 16'hFFFF, 16'd0, 1'b0);
                2: apply_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
                3: begin
                    mn = $urandom_range(0, 30000);
                    mx = mn + $urandom_range(0, 35535);
                    apply_config(t_dist'(mn), t_dist'(mx),
                                 t_dist'($urandom_range(0, 2000)), 1'b0);
                end
                4: begin
                    mx = $urandom_range(0, 30000);
                    mn = mx + $urandom_range(1, 35535);
                    apply_config(t_dist'(mn), t_dist'(mx),
                                 t_dist'($urandom_range(0, 2000)), 1'b0);
                end
                default: begin
                    mn = $urandom_range(0, 3000);
                    mx = $urandom_range(3000, 65535);
                    apply_config(t_dist'(mn), t_dist'(mx),
                                 t_dist'($urandom_range(0, 65535)), 1'b1);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 20) stall_req = ~stall_req;
                push_frame(next_frame());
            end
        end
        calm = 1'b0;
        settle();

        $display("summary: %0d frames over %0d register settings, %0d results checked",
                 sent, setting_count, checked);
        $display("summary: %0d spike rejections seen, one long result stall applied",
                 spikes);
        if (fail_count == 0 && pending == 0) begin
            $display("range_frame_check_trimmed_mean_unit regression: pass");
        end else begin
            $display("range_frame_check_trimmed_mean_unit regression: fail");
        end
        $finish;
    end

endmodule
